// ----- sv/ultrasonic_range_controller_macros.svh -----
// ----------------------------------------------------------------------------
// ultrasonic range controller assertion macros
// shorthand for clocked checks that are disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH
`define ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define URC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define URC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/urc_pkg.sv -----
// ----------------------------------------------------------------------------
// urc_pkg
// shared widths, register codes, reset values and phase encoding
// ----------------------------------------------------------------------------
`default_nettype none

package urc_pkg;

  // register widths
  localparam int unsigned IntervalW  = 20;
  localparam int unsigned PulseW     = 8;
  localparam int unsigned TimeoutW   = 17;
  localparam int unsigned DistW      = 16;
  localparam int unsigned CountW     = 17;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned CfgIdxW    = 2;

  // reset values of the configuration registers
  localparam logic [IntervalW-1:0] IntervalRst  = 20'd60000;
  localparam logic [PulseW-1:0]    PulseRst     = 8'd10;
  localparam logic [TimeoutW-1:0]  TimeoutRst   = 17'd30000;
  localparam logic [DistW-1:0]     ThresholdRst = 16'd300;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // width * 343 / 2000 as one multiply by a scaled reciprocal:
  // recip = ceil(343 * 2^29 / 2000), exact for every 17 bit width
  localparam int unsigned RecipW    = 27;
  localparam int unsigned RecipShift = 29;
  localparam logic [RecipW-1:0] DistRecip = 27'd92073362;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIG_INTERVAL = 2'd0,
    REG_TRIG_PULSE    = 2'd1,
    REG_ECHO_TIMEOUT  = 2'd2,
    REG_OBST_THRESH   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_e;

endpackage

`default_nettype wire

// ----- sv/urc_if.sv -----
// ----------------------------------------------------------------------------
// urc_if
// valid/ready channels for echo samples and ranging results
// ----------------------------------------------------------------------------
`default_nettype none

interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface urc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        trig_level;
  logic [urc_pkg::DistW-1:0]   distance_mm;
  logic                        reading_valid;
  logic                        obst_near;
  logic                        new_reading;
  logic                        timed_out;

  modport source (output valid, output trig_level, output distance_mm,
                  output reading_valid, output obst_near,
                  output new_reading, output timed_out, input ready);
  modport sink   (input valid, input trig_level, input distance_mm,
                  input reading_valid, input obst_near,
                  input new_reading, input timed_out, output ready);
endinterface

`default_nettype wire

// ----- sv/urc_dist_conv.sv -----
// ----------------------------------------------------------------------------
// urc_dist_conv
// echo width in microseconds to distance in millimetres
// ----------------------------------------------------------------------------
`default_nettype none

module urc_dist_conv (
  input  wire logic [urc_pkg::CountW-1:0] width_i,
  output logic      [urc_pkg::DistW-1:0]  dist_o
);

  localparam int unsigned ProdW = urc_pkg::CountW + urc_pkg::RecipW;
  localparam int unsigned QuotW = ProdW - urc_pkg::RecipShift;

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;

  assign prod = ProdW'(width_i) * ProdW'(urc_pkg::DistRecip);
  assign quot = prod[ProdW-1:urc_pkg::RecipShift];

  // largest width gives 22478 mm, so the clamp only guards the top bits
  assign dist_o = (quot > QuotW'({urc_pkg::DistW{1'b1}})) ? {urc_pkg::DistW{1'b1}}
                                                           : urc_pkg::DistW'(quot);

endmodule

`default_nettype wire

// ----- sv/ultrasonic_range_controller.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_range_controller
// trigger/echo ranging sensor controller driven by microsecond ticks
// ----------------------------------------------------------------------------
// Each item on echo_i is one microsecond tick carrying the sampled echo pin.
// Every item yields exactly one result item on result_o in the next clock,
// and a new item is taken every clock as long as the result register is
// empty or being drained (throughput one item per cycle). The tick
// work is one combinational pass from the state registers to the result
// register; its longest path is the 17x27 bit reciprocal multiply that turns
// echo width into millimetres (width * 343 / 2000, exact). When idle and the
// trigger interval has elapsed the block raises trig_level for
// trigger_pulse_us ticks, then waits for the echo, counts its high samples and
// reports the distance on the first low sample (new_reading pulses). If no
// echo completes within the echo timeout after the trigger, reading_valid
// drops and timed_out pulses. obst_near is reading_valid and distance
// below obstacle_threshold_mm. Configuration through cfg_we_i / cfg_idx_i /
// cfg_data_i must be written while no tick is in flight; no logic enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_controller #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [urc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [urc_pkg::CfgDataW-1:0] cfg_data_i,
  urc_in_if.sink                            echo_i,
  urc_out_if.source                         result_o
);

  `include "ultrasonic_range_controller_macros.svh"

  // compare width wide enough for both the interval counter and its limit
  localparam int unsigned CmpW =
    (TIMER_BITS > urc_pkg::IntervalW) ? TIMER_BITS : urc_pkg::IntervalW;
  localparam logic [TIMER_BITS-1:0] IcMax = {TIMER_BITS{1'b1}};

  // configuration registers
  logic [urc_pkg::IntervalW-1:0] cfg_interval_q;
  logic [urc_pkg::PulseW-1:0]    cfg_pulse_q;
  logic [urc_pkg::TimeoutW-1:0]  cfg_timeout_q;
  logic [urc_pkg::DistW-1:0]     cfg_thresh_q;

  // ranging state
  urc_pkg::phase_e               phase_q, phase_d;
  logic [TIMER_BITS-1:0]         ic_q, ic_d;
  logic [urc_pkg::PulseW-1:0]    pc_q, pc_d;
  logic [urc_pkg::CountW-1:0]    st_q, st_d;
  logic [urc_pkg::CountW-1:0]    ew_q, ew_d;
  logic [urc_pkg::DistW-1:0]     dist_q, dist_d;
  logic                          vld_q, vld_d;

  // result register
  logic                          out_valid_q;
  logic                          trig_q, trig_d;
  logic [urc_pkg::DistW-1:0]     out_dist_q;
  logic                          out_vld_q;
  logic                          near_q, near_d;
  logic                          fresh_q, fresh_d;
  logic                          tout_q, tout_d;

  logic                          in_accept;
  logic [urc_pkg::DistW-1:0]     conv_dist;

  // output register parts the two sides: take a tick whenever it can drain
  assign echo_i.ready = !out_valid_q || result_o.ready;
  assign in_accept    = echo_i.valid && echo_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_interval_q <= urc_pkg::IntervalRst;
      cfg_pulse_q    <= urc_pkg::PulseRst;
      cfg_timeout_q  <= urc_pkg::TimeoutRst;
      cfg_thresh_q   <= urc_pkg::ThresholdRst;
    end else if (cfg_we_i) begin
      case (urc_pkg::cfg_reg_e'(cfg_idx_i))
        urc_pkg::REG_TRIG_INTERVAL: cfg_interval_q <= cfg_data_i[urc_pkg::IntervalW-1:0];
        urc_pkg::REG_TRIG_PULSE:    cfg_pulse_q    <= cfg_data_i[urc_pkg::PulseW-1:0];
        urc_pkg::REG_ECHO_TIMEOUT:  cfg_timeout_q  <= cfg_data_i[urc_pkg::TimeoutW-1:0];
        urc_pkg::REG_OBST_THRESH:   cfg_thresh_q   <= cfg_data_i[urc_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  // distance from the width counted so far, used on the closing low sample
  urc_dist_conv u_dist_conv (
    .width_i (ew_q),
    .dist_o  (conv_dist)
  );

  // one tick of the ranging sequence
  always_comb begin
    phase_d = phase_q;
    pc_d    = pc_q;
    st_d    = st_q;
    ew_d    = ew_q;
    dist_d  = dist_q;
    vld_d   = vld_q;
    trig_d  = 1'b0;
    fresh_d = 1'b0;
    tout_d  = 1'b0;

    // free-running interval counter, sticks at all ones
    ic_d = (ic_q != IcMax) ? ic_q + TIMER_BITS'(1) : ic_q;

    case (phase_q)
      urc_pkg::PH_TRIG: begin
        st_d = (st_q != urc_pkg::CountMax) ? st_q + urc_pkg::CountW'(1) : st_q;
        pc_d = pc_q + urc_pkg::PulseW'(1);
        // a zero pulse length behaves as one tick
        if (pc_d >= cfg_pulse_q || pc_d == '0) begin
          phase_d = urc_pkg::PH_WAIT;
        end else begin
          trig_d = 1'b1;
        end
      end
      urc_pkg::PH_WAIT, urc_pkg::PH_MEAS: begin
        st_d = (st_q != urc_pkg::CountMax) ? st_q + urc_pkg::CountW'(1) : st_q;
        if (phase_q == urc_pkg::PH_WAIT) begin
          if (echo_i.echo_level) begin
            phase_d = urc_pkg::PH_MEAS;
            ew_d    = urc_pkg::CountW'(1);
          end
        end else if (echo_i.echo_level) begin
          ew_d = (ew_q != urc_pkg::CountMax) ? ew_q + urc_pkg::CountW'(1) : ew_q;
        end else begin
          // falling edge of echo closes the measurement
          dist_d  = conv_dist;
          vld_d   = 1'b1;
          fresh_d = 1'b1;
          phase_d = urc_pkg::PH_IDLE;
        end
        // timeout, unless the reading completed on this tick
        if (phase_d != urc_pkg::PH_IDLE &&
            (st_d > cfg_timeout_q || st_d == urc_pkg::CountMax)) begin
          phase_d = urc_pkg::PH_IDLE;
          vld_d   = 1'b0;
          tout_d  = 1'b1;
        end
      end
      default: ;
    endcase

    // start a new trigger on the same tick the block is idle and due
    if (phase_d == urc_pkg::PH_IDLE &&
        (CmpW'(ic_d) >= CmpW'(cfg_interval_q) || ic_d == IcMax)) begin
      phase_d = urc_pkg::PH_TRIG;
      pc_d    = '0;
      st_d    = '0;
      ic_d    = '0;
      trig_d  = 1'b1;
    end

    near_d = vld_d && (dist_d < cfg_thresh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= urc_pkg::PH_IDLE;
      ic_q    <= '0;
      pc_q    <= '0;
      st_q    <= '0;
      ew_q    <= '0;
      dist_q  <= '0;
      vld_q   <= 1'b0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      ic_q    <= ic_d;
      pc_q    <= pc_d;
      st_q    <= st_d;
      ew_q    <= ew_d;
      dist_q  <= dist_d;
      vld_q   <= vld_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      trig_q     <= trig_d;
      out_dist_q <= dist_d;
      out_vld_q  <= vld_d;
      near_q     <= near_d;
      fresh_q    <= fresh_d;
      tout_q     <= tout_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.trig_level    = trig_q;
  assign result_o.distance_mm   = out_dist_q;
  assign result_o.reading_valid = out_vld_q;
  assign result_o.obst_near     = near_q;
  assign result_o.new_reading   = fresh_q;
  assign result_o.timed_out     = tout_q;

  // checks
  `URC_ASSERT_NEXT(a_tick_gives_result, in_accept, out_valid_q, "accepted tick lost its result")
  `URC_ASSERT_SAME(a_done_xor_tout, out_valid_q, !(fresh_q && tout_q), "both done and timeout")
  `URC_ASSERT_SAME(a_tout_clears_valid, out_valid_q && tout_q, !out_vld_q, "timeout kept valid")
  `URC_ASSERT_SAME(a_near_needs_valid, out_valid_q && near_q, out_vld_q, "near on invalid reading")

endmodule

`default_nettype wire
